>>> rtl/gre_voxel_intensity_core_macros.svh
// Assertion macros used by the checker of the voxel intensity core.
// Each macro samples on clk and is disabled while rst is high.
`ifndef GRE_VOXEL_INTENSITY_CORE_MACROS_SVH
`define GRE_VOXEL_INTENSITY_CORE_MACROS_SVH

// Same-cycle implication.
`define GVI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gvi check failed: same-cycle rule");

// Next-cycle implication.
`define GVI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gvi check failed: next-cycle rule");

`endif

>>> rtl/gvi_pkg.sv
// Package of the voxel intensity core: widths, fixed-point constants,
// pipeline depths, register codes and shared types. No dependencies.
`default_nettype none

package gvi_pkg;

  // Field widths
  localparam int TIME_W     = 16;
  localparam int T_W        = 20;
  localparam int GD_W       = 14;
  localparam int REL_W      = 12;
  localparam int INT_W      = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Datapath widths
  localparam int RATE_Q_W = 32;  // quotient of (time << 16) / T
  localparam int TERM_W   = 27;  // agent term added to an exponent
  localparam int X_W      = 33;  // Q16 exponent
  localparam int Q30_W    = 31;  // Q30 values up to and including one
  localparam int FRAC_W   = 30;

  // Pipeline depths
  localparam int RATE_STEPS  = 4;
  localparam int RATE_DEPTH  = RATE_Q_W / RATE_STEPS + 1;
  localparam int HORNER_K    = 12;
  localparam int EXP_DEPTH   = 3 + 2 * HORNER_K + 1;
  localparam int SIG_DEPTH   = 12;
  localparam int PIPE_DEPTH  = RATE_DEPTH + EXP_DEPTH + SIG_DEPTH;
  localparam int EXP_BASE    = RATE_DEPTH;
  localparam int SIG_BASE    = RATE_DEPTH + EXP_DEPTH;
  localparam int CNT_W       = $clog2(PIPE_DEPTH + 1);

  // Fixed-point constants
  localparam logic [Q30_W-1:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [29:0]      LN2_Q30   = 30'd744261118;
  localparam logic [28:0]      SIN20_Q30 = 29'd367241333;
  localparam logic [29:0]      COS20_Q30 = 30'd1008987269;
  localparam logic [X_W-1:0]   X_LIMIT   = 33'h0_0040_0000;   // 64.0 in Q16
  localparam logic [14:0]      LN2_RECIP = 15'((64'd1 << 44) / 64'd744261118);
  localparam logic [28:0]      RECIP_125 = 29'((64'd1 << 35) / 64'd125);
  localparam logic [29:0]      RECIP_25  = 30'((64'd1 << 34) / 64'd25);

  // ceil(2^34 / k): exact quotient for 30-bit dividends
  localparam logic [34:0] RECIP_K [1:12] = '{
    35'(((64'd1 << 34) + 64'd0) / 64'd1),
    35'(((64'd1 << 34) + 64'd1) / 64'd2),
    35'(((64'd1 << 34) + 64'd2) / 64'd3),
    35'(((64'd1 << 34) + 64'd3) / 64'd4),
    35'(((64'd1 << 34) + 64'd4) / 64'd5),
    35'(((64'd1 << 34) + 64'd5) / 64'd6),
    35'(((64'd1 << 34) + 64'd6) / 64'd7),
    35'(((64'd1 << 34) + 64'd7) / 64'd8),
    35'(((64'd1 << 34) + 64'd8) / 64'd9),
    35'(((64'd1 << 34) + 64'd9) / 64'd10),
    35'(((64'd1 << 34) + 64'd10) / 64'd11),
    35'(((64'd1 << 34) + 64'd11) / 64'd12)
  };

  // Register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TR  = 2'd0,
    REG_TE  = 2'd1,
    REG_GD  = 2'd2,
    REG_REL = 2'd3
  } cfg_reg_t;

  // Configuration view handed to the datapath
  typedef struct packed {
    logic [TIME_W-1:0] tr;
    logic [TIME_W-1:0] te;
    logic [TERM_W-1:0] term1;
    logic [TERM_W-1:0] term2;
  } cfg_view_t;

endpackage

`default_nettype wire

>>> rtl/gvi_voxel_if.sv
// Input channel of the voxel intensity core: one voxel's T1 and T2 per beat.
// Depends on gvi_pkg.
`default_nettype none

interface gvi_voxel_if import gvi_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [T_W-1:0] tissue_t1;
  logic [T_W-1:0] tissue_t2;

  modport source(output valid, tissue_t1, tissue_t2, input ready);
  modport sink(input valid, tissue_t1, tissue_t2, output ready);
  modport monitor(input valid, ready, tissue_t1, tissue_t2);
endinterface

`default_nettype wire

>>> rtl/gvi_intensity_if.sv
// Output channel of the voxel intensity core: one intensity byte per beat.
// Depends on gvi_pkg.
`default_nettype none

interface gvi_intensity_if import gvi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [INT_W-1:0] intensity;

  modport source(output valid, intensity, input ready);
  modport sink(input valid, intensity, output ready);
  modport monitor(input valid, ready, intensity);
endinterface

`default_nettype wire

>>> rtl/gvi_cfg.sv
// Configuration registers and the agent terms derived from them.
// Depends on gvi_pkg.
`default_nettype none

module gvi_cfg import gvi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_view_t             view
);

  logic [TIME_W-1:0] tr;
  logic [TIME_W-1:0] te;
  logic [GD_W-1:0]   gd;
  logic [REL_W-1:0]  rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      tr  <= 16'd80;
      te  <= 16'd32;
      gd  <= '0;
      rel <= 12'd1152;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TR:  tr  <= cfg_data;
        REG_TE:  te  <= cfg_data;
        REG_GD:  gd  <= cfg_data[GD_W-1:0];
        REG_REL: rel <= cfg_data[REL_W-1:0];
      endcase
    end
  end

  // T1 term: floor(TR*rel*Gd / 64000) = floor(floor(p / 512) / 125)
  logic [27:0] p1;
  logic [41:0] p2;
  logic [32:0] a1;
  logic [61:0] m1;
  logic [TERM_W-1:0] term1;
  logic [26:0] q1;
  logic [33:0] r1;

  // T2 term: floor(TE*Gd / 50) = floor(floor(p / 2) / 25)
  logic [29:0] p3;
  logic [28:0] a2;
  logic [58:0] m2;
  logic [TERM_W-1:0] term2;
  logic [24:0] q2;
  logic [29:0] r2;

  always_comb begin
    q1 = m1[61:35];
    r1 = {1'b0, a1} - 34'(q1 * 34'd125);
    q2 = m2[58:34];
    r2 = {1'b0, a2} - 30'(q2 * 30'd25);
  end

  always_ff @(posedge clk) begin
    p1    <= 28'(tr * rel);
    p2    <= 42'(p1 * gd);
    a1    <= p2[41:9];
    m1    <= 62'(p2[41:9] * RECIP_125);
    term1 <= (r1 >= 34'd125) ? TERM_W'(q1 + 27'd1) : TERM_W'(q1);
    p3    <= 30'(te * gd);
    a2    <= p3[29:1];
    m2    <= 59'(p3[29:1] * RECIP_25);
    term2 <= (r2 >= 30'd25) ? TERM_W'(q2 + 25'd1) : TERM_W'(q2);
  end

  assign view = '{tr: tr, te: te, term1: term1, term2: term2};

endmodule

`default_nettype wire

>>> rtl/gvi_rate.sv
// Rate pipeline: restoring divide of (time << 16) by T, four quotient bits
// per stage, then the agent term. Depends on gvi_pkg.
`default_nettype none

module gvi_rate import gvi_pkg::*; (
  input  logic                  clk,
  input  logic [RATE_DEPTH-1:0] ld,
  input  logic [TIME_W-1:0]     time_val,
  input  logic [T_W-1:0]        t_in,
  input  logic [TERM_W-1:0]     term,
  output logic [X_W-1:0]        x
);

  localparam int DIV_ST = RATE_DEPTH - 1;

  function automatic logic [T_W+RATE_Q_W-1:0] div_steps(
    input logic [T_W-1:0] rem, input logic [RATE_Q_W-1:0] acc,
    input logic [T_W-1:0] dv);
    logic [T_W-1:0]      r;
    logic [RATE_Q_W-1:0] a;
    logic [T_W:0]        sh;
    r = rem;
    a = acc;
    for (int s = 0; s < RATE_STEPS; s++) begin
      sh = {r, a[RATE_Q_W-1]};
      a  = {a[RATE_Q_W-2:0], 1'b0};
      if (sh >= {1'b0, dv}) begin
        sh   = sh - {1'b0, dv};
        a[0] = 1'b1;
      end
      r = sh[T_W-1:0];
    end
    return {r, a};
  endfunction

  logic [T_W-1:0]      rem_st  [DIV_ST];
  logic [RATE_Q_W-1:0] acc_st  [DIV_ST];
  logic [T_W-1:0]      dv_st   [DIV_ST];
  logic                zero_st [DIV_ST];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      {rem_st[0], acc_st[0]} <= div_steps('0, {time_val, 16'h0000}, t_in);
      dv_st[0]   <= t_in;
      zero_st[0] <= (t_in == '0);
    end
  end

  for (genvar i = 1; i < DIV_ST; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (ld[i]) begin
        {rem_st[i], acc_st[i]} <= div_steps(rem_st[i-1], acc_st[i-1], dv_st[i-1]);
        dv_st[i]   <= dv_st[i-1];
        zero_st[i] <= zero_st[i-1];
      end
    end
  end

  // Saturate the exponent on a zero T.
  always_ff @(posedge clk) begin
    if (ld[DIV_ST]) begin
      x <= zero_st[DIV_ST-1] ? X_LIMIT
                             : X_W'({1'b0, acc_st[DIV_ST-1]}) + X_W'(term);
    end
  end

endmodule

`default_nettype wire

>>> rtl/gvi_exp.sv
// exp(-x) pipeline: range reduction by ln 2, a twelve-term Horner series,
// then the power-of-two shift. Q16 in, Q30 out. Depends on gvi_pkg.
`default_nettype none

module gvi_exp import gvi_pkg::*; (
  input  logic                 clk,
  input  logic [EXP_DEPTH-1:0] ld,
  input  logic [X_W-1:0]       x,
  output logic [Q30_W-1:0]     e
);

  localparam int HS = 2 * HORNER_K;

  // Range reduction
  logic [21:0] xs0;
  logic        sat0;
  logic [36:0] prod0;
  logic [6:0]  n1;
  logic [30:0] r1;
  logic        sat1;
  logic [36:0] r1_full;

  always_comb begin
    r1_full = {1'b0, xs0, 14'h0000} - 37'(prod0[36:30] * LN2_Q30);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      xs0   <= x[21:0];
      sat0  <= (x >= X_LIMIT);
      prod0 <= 37'(x[21:0] * LN2_RECIP);
    end
    if (ld[1]) begin
      n1   <= prod0[36:30];
      r1   <= r1_full[30:0];
      sat1 <= sat0;
    end
  end

  // Horner carriers: index 0 is the reduced argument, h = 1..24 the steps
  logic [29:0] r_h   [HS];
  logic [6:0]  n_h   [HS+1];
  logic        sat_h [HS+1];
  logic [29:0] val_h [1:HS];

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      if (r1 >= {1'b0, LN2_Q30}) begin
        r_h[0] <= 30'(r1 - {1'b0, LN2_Q30});
        n_h[0] <= n1 + 7'd1;
      end else begin
        r_h[0] <= r1[29:0];
        n_h[0] <= n1;
      end
      sat_h[0] <= sat1;
    end
  end

  for (genvar j = 0; j < HORNER_K; j++) begin : g_step
    localparam int HA = 2 * j + 1;
    localparam int HB = 2 * j + 2;
    logic [Q30_W-1:0] t_in;
    logic [60:0]      rt;
    logic [64:0]      pq;

    always_comb begin
      t_in = (j == 0) ? ONE_Q30 : ONE_Q30 - Q30_W'(val_h[HA-1 + ((j == 0) ? 1 : 0)]);
      rt   = 61'(r_h[HA-1] * t_in);
      pq   = 65'(val_h[HA] * RECIP_K[HORNER_K - j]);
    end

    // Multiply r by t.
    always_ff @(posedge clk) begin
      if (ld[2 + HA]) begin
        val_h[HA] <= rt[59:30];
        n_h[HA]   <= n_h[HA-1];
        sat_h[HA] <= sat_h[HA-1];
        if (HA < HS) begin
          r_h[HA] <= r_h[HA-1];
        end
      end
    end

    // Divide by k.
    always_ff @(posedge clk) begin
      if (ld[2 + HB]) begin
        val_h[HB] <= pq[63:34];
        n_h[HB]   <= n_h[HB-1];
        sat_h[HB] <= sat_h[HB-1];
      end
    end

    // Carry the reduced argument on to the next step.
    if (j < HORNER_K - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ld[2 + HB]) begin
          r_h[HB] <= r_h[HB-1];
        end
      end
    end
  end

  logic [Q30_W-1:0] t_fin;
  assign t_fin = ONE_Q30 - Q30_W'(val_h[HS]);

  always_ff @(posedge clk) begin
    if (ld[EXP_DEPTH-1]) begin
      e <= (sat_h[HS] || (n_h[HS] >= 7'd31)) ? '0 : (t_fin >> n_h[HS]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/gvi_signal.sv
// Signal equation: sin(a)(1-E1)/(1-E1 cos(a)) by a restoring divider,
// times E2, scaled to 0..255. Depends on gvi_pkg.
`default_nettype none

module gvi_signal import gvi_pkg::*; (
  input  logic                 clk,
  input  logic [SIG_DEPTH-1:0] ld,
  input  logic [Q30_W-1:0]     e1,
  input  logic [Q30_W-1:0]     e2,
  output logic [INT_W-1:0]     intensity
);

  localparam int DSTG = 8;

  function automatic logic [Q30_W+FRAC_W-1:0] div_steps(
    input logic [Q30_W-1:0] rem, input logic [FRAC_W-1:0] acc,
    input logic [Q30_W-1:0] den, input int ns);
    logic [Q30_W-1:0]  r;
    logic [FRAC_W-1:0] a;
    logic [Q30_W:0]    sh;
    r = rem;
    a = acc;
    for (int s = 0; s < 4; s++) begin
      if (s < ns) begin
        sh = {r, a[FRAC_W-1]};
        a  = {a[FRAC_W-2:0], 1'b0};
        if (sh >= {1'b0, den}) begin
          sh   = sh - {1'b0, den};
          a[0] = 1'b1;
        end
        r = sh[Q30_W-1:0];
      end
    end
    return {r, a};
  endfunction

  // Numerator and E1*cos product
  logic [59:0]      num0;
  logic [60:0]      dp0;
  logic [Q30_W-1:0] e2_0;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      num0 <= 60'(SIN20_Q30 * (ONE_Q30 - e1));
      dp0  <= 61'(e1 * COS20_Q30);
      e2_0 <= e2;
    end
  end

  // Divider stages; index 0 holds the setup
  logic [Q30_W-1:0]  rem_d [DSTG+1];
  logic [FRAC_W-1:0] acc_d [DSTG+1];
  logic [Q30_W-1:0]  den_d [DSTG+1];
  logic [Q30_W-1:0]  e2_d  [DSTG+1];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      rem_d[0] <= Q30_W'(num0[58:30]);
      acc_d[0] <= num0[29:0];
      den_d[0] <= ONE_Q30 - dp0[60:30];
      e2_d[0]  <= e2_0;
    end
  end

  for (genvar d = 1; d <= DSTG; d++) begin : g_div
    localparam int NS = (d <= 6) ? 4 : 3;
    always_ff @(posedge clk) begin
      if (ld[d + 1]) begin
        {rem_d[d], acc_d[d]} <= div_steps(rem_d[d-1], acc_d[d-1], den_d[d-1], NS);
        den_d[d] <= den_d[d-1];
        e2_d[d]  <= e2_d[d-1];
      end
    end
  end

  logic [60:0]      fe;
  logic [Q30_W-1:0] s10;
  logic [38:0]      sv;

  assign fe = 61'(acc_d[DSTG] * e2_d[DSTG]);
  assign sv = 39'(s10 * 8'd255);

  always_ff @(posedge clk) begin
    if (ld[SIG_DEPTH-2]) begin
      s10 <= fe[60:30];
    end
    if (ld[SIG_DEPTH-1]) begin
      intensity <= (sv[38:30] > 9'd255) ? 8'd255 : sv[37:30];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gre_voxel_intensity_core.sv
// Spoiled gradient-echo voxel intensity core.
// Every pipeline stage, from voxel beat to intensity beat, is a register with its own valid bit.
// Throughput: one voxel per cycle while the output drains or a stage is empty. Output stall:
// stages up to the last empty one keep moving, so input is taken while a result waits.
// Reset (rst, synchronous): clears all valid bits and loads the register defaults.
// Derived agent terms are registered and settle after reset or a register write.
`default_nettype none

module gre_voxel_intensity_core import gvi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gvi_voxel_if.sink             voxel,
  gvi_intensity_if.source       result
);

  localparam logic [PIPE_DEPTH-1:0] ONES = '1;

  cfg_view_t cfg;

  // One valid bit per stage; ld loads a stage from the one before it.
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] ld;

  // A stage may load when the output drains or a bubble sits at or after it.
  always_comb begin
    for (int i = 0; i < PIPE_DEPTH; i++) begin
      ld[i] = result.ready || ((~vld & (ONES << i)) != '0);
    end
  end

  // Advance valid bits where loaded; hold them elsewhere.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~ld) | ({vld[PIPE_DEPTH-2:0], voxel.valid} & ld);
    end
  end

  assign voxel.ready  = ld[0];
  assign result.valid = vld[PIPE_DEPTH-1];

  gvi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (cfg)
  );

  // Exponents TR/T1a and TE/T2a in Q16
  logic [X_W-1:0] x1;
  logic [X_W-1:0] x2;

  gvi_rate u_rate1 (
    .clk      (clk),
    .ld       (ld[RATE_DEPTH-1:0]),
    .time_val (cfg.tr),
    .t_in     (voxel.tissue_t1),
    .term     (cfg.term1),
    .x        (x1)
  );

  gvi_rate u_rate2 (
    .clk      (clk),
    .ld       (ld[RATE_DEPTH-1:0]),
    .time_val (cfg.te),
    .t_in     (voxel.tissue_t2),
    .term     (cfg.term2),
    .x        (x2)
  );

  // E1 and E2 in Q30
  logic [Q30_W-1:0] e1;
  logic [Q30_W-1:0] e2;

  gvi_exp u_exp1 (
    .clk (clk),
    .ld  (ld[SIG_BASE-1:EXP_BASE]),
    .x   (x1),
    .e   (e1)
  );

  gvi_exp u_exp2 (
    .clk (clk),
    .ld  (ld[SIG_BASE-1:EXP_BASE]),
    .x   (x2),
    .e   (e2)
  );

  // Last stage of the signal pipeline is the output register.
  gvi_signal u_signal (
    .clk       (clk),
    .ld        (ld[PIPE_DEPTH-1:SIG_BASE]),
    .e1        (e1),
    .e2        (e2),
    .intensity (result.intensity)
  );

endmodule

`default_nettype wire

>>> rtl/gvi_checker.sv
// Port-level checker for the voxel intensity core, bound to the top level.
// Depends on gvi_pkg and the assertion macros.
`default_nettype none

`include "gre_voxel_intensity_core_macros.svh"

module gvi_checker import gvi_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [INT_W-1:0] intensity
);

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;
  logic             in_beat;
  logic             out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    inflight_next = inflight + CNT_W'(in_beat) - CNT_W'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `GVI_ASSERT_NXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(intensity))
  `GVI_ASSERT_IMP(a_ready_on_drain, out_ready, in_ready)
  `GVI_ASSERT_IMP(a_depth_bound, 1'b1, inflight <= CNT_W'(PIPE_DEPTH))
  `GVI_ASSERT_IMP(a_no_phantom, out_valid, inflight != '0)

endmodule

bind gre_voxel_intensity_core gvi_checker u_gvi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (voxel.valid),
  .in_ready  (voxel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .intensity (result.intensity)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of gre_voxel_intensity_core: streams voxel T1/T2 beats under
// several register settings and handshake patterns, and predicts each intensity in fixed point.
// Depends on gvi_pkg, gvi_voxel_if, gvi_intensity_if and the core itself.
`timescale 1ns / 100ps

module tb_top;
  import gvi_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 8;    // lets the derived agent terms settle after a write
  localparam int DRAIN_TAIL   = 60;   // extra wait once every predicted intensity has come out

  localparam logic [63:0] ONE_Q = 64'd1 << 30;
  localparam logic [63:0] LN2_Q = 64'd744261118;
  localparam logic [63:0] SIN_Q = 64'd367241333;
  localparam logic [63:0] COS_Q = 64'd1008987269;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gvi_voxel_if     voxel_ch();
  gvi_intensity_if result_ch();

  gre_voxel_intensity_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxel     (voxel_ch.sink),
    .result    (result_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, as the core sees it after a write.
  logic [15:0] tr_reg, te_reg;
  logic [13:0] gd_reg;
  logic [11:0] rel_reg;

  logic [7:0] intensity_q[$];   // predicted intensities, oldest first
  int         errors = 0;
  int         voxels_sent = 0;
  int         beats_checked = 0;
  int         cycles = 0;
  int         src_idle = 0;     // percent of cycles the sender idles
  int         snk_stall = 0;    // percent of cycles the receiver stalls
  int         hold_req = 0;     // long receiver hold-off, handed over at a falling edge
  int         hold_left = 0;

  // exp(-x) of a Q16 exponent, returned in Q30.
  function automatic logic [63:0] decay_q30(input logic [63:0] x_q16);
    logic [63:0] xq, n, r, t;
    if (x_q16 >= (64'd64 << 16)) return 64'd0;
    xq = x_q16 << 14;
    n  = xq / LN2_Q;
    r  = xq - n * LN2_Q;
    t  = ONE_Q;
    for (int k = 12; k >= 1; k--) t = ONE_Q - ((r * t) >> 30) / k;
    if (n >= 31) return 64'd0;
    return t >> n;
  endfunction

  function automatic logic [7:0] gre_intensity(input logic [19:0] t1, input logic [19:0] t2);
    logic [63:0] e1, e2, x1, x2, num, den, f, s, v;
    if (t2 == 0) return 8'd0;    // saturated T2 rate kills the echo
    if (t1 == 0) e1 = 0;         // saturated T1 rate: full recovery, even at zero TR
    else begin
      x1 = ({48'd0, tr_reg} << 16) / t1 + (64'(tr_reg) * rel_reg * gd_reg) / 64'd64000;
      e1 = decay_q30(x1);
    end
    x2  = ({48'd0, te_reg} << 16) / t2 + (64'(te_reg) * gd_reg) / 64'd50;
    e2  = decay_q30(x2);
    num = SIN_Q * (ONE_Q - e1);
    den = ONE_Q - ((e1 * COS_Q) >> 30);
    f   = num / den;
    s   = (f * e2) >> 30;
    v   = (s * 255) >> 30;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // Check each output beat against the oldest prediction. Sample mid-cycle so
  // the values are settled; the beat itself completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (intensity_q.size() == 0) begin
        $display("%0t: unexpected intensity beat, expected none, actual %0d",
                 $time, result_ch.intensity);
        errors++;
      end else begin
        logic [7:0] want;
        want = intensity_q.pop_front();
        if (result_ch.intensity !== want) begin
          $display("%0t: intensity expected %0d, actual %0d", $time, want,
                   result_ch.intensity);
          errors++;
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d intensities outstanding", cycles,
               intensity_q.size());
      $display("gre_voxel_intensity_core: mismatch");
      $finish;
    end
  end

  // Drive one register write; the caller drops the write enable.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Rewrite every register (core idle), update the shadow copy, let the terms settle.
  task automatic set_config(input logic [15:0] tr, te, gd, rel);
    write_reg(REG_TR, tr);
    write_reg(REG_TE, te);
    write_reg(REG_GD, gd);
    write_reg(REG_REL, rel);
    cfg_wr_en <= 1'b0;
    tr_reg  = tr;
    te_reg  = te;
    gd_reg  = gd[13:0];
    rel_reg = rel[11:0];
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one voxel beat, after an optional random gap, and hold it until taken.
  // Valid stays high on return so back-to-back beats keep streaming.
  task automatic send_voxel(input logic [19:0] t1, input logic [19:0] t2);
    bit taken;
    while ($urandom_range(99) < src_idle) begin
      voxel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    voxel_ch.valid     <= 1'b1;
    voxel_ch.tissue_t1 <= t1;
    voxel_ch.tissue_t2 <= t2;
    do begin
      @(negedge clk);
      taken = voxel_ch.valid && voxel_ch.ready;
      @(posedge clk);
    end while (!taken);
    intensity_q.push_back(gre_intensity(t1, t2));
    voxels_sent++;
  endtask

  // Drop valid and wait until every predicted intensity has come out.
  task automatic drain;
    voxel_ch.valid <= 1'b0;
    while (intensity_q.size() > 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Mostly tissue-like times so intensities land well above zero, with full-range
  // values and tiny values mixed in to toggle every bit and hit the rate extremes.
  function automatic logic [19:0] tissue_time(input bit is_t2);
    unique case ($urandom_range(3))
      0:       return 20'($urandom);
      1:       return 20'($urandom_range(15));
      default: return is_t2 ? 20'($urandom_range(2000, 80000))
                            : 20'($urandom_range(3000, 60000));
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_voxel(tissue_time(1'b0), tissue_time(1'b1));
  endtask

  task automatic test_directed;
    src_idle  = 0;
    snk_stall = 0;
    set_config(16'd80, 16'd32, 16'd0, 16'd1152);
    send_voxel(20'd0, 20'd0);               // both rates saturated
    send_voxel(20'd0, 20'd1600);            // zero T1: full recovery
    send_voxel(20'd16000, 20'd0);           // zero T2: no signal
    send_voxel(20'hFFFFF, 20'hFFFFF);
    send_voxel(20'd1, 20'd1);
    send_voxel(20'hFFFFF, 20'd1);
    send_voxel(20'd1, 20'hFFFFF);
    send_voxel(20'd0, 20'hFFFFF);
    send_voxel(20'd14000, 20'd1600);
    drain();
    // Zero TR with a real T1 gives no recovery; zero T1 still recovers fully.
    set_config(16'd0, 16'd0, 16'd2048, 16'd1152);
    send_voxel(20'd5, 20'd100);
    send_voxel(20'd0, 20'd100);
    send_voxel(20'hFFFFF, 20'hFFFFF);
    drain();
    // Every register at its top: exponents run past the exp cutoff.
    set_config(16'hFFFF, 16'hFFFF, 16'h3FFF, 16'h0FFF);
    send_voxel(20'hFFFFF, 20'hFFFFF);
    send_voxel(20'd1, 20'd1);
    send_voxel(20'd0, 20'hFFFFF);
    send_voxel(20'd40000, 20'd3000);
    drain();
    // Short TR with a long TE and no agent.
    set_config(16'd1, 16'd4000, 16'd0, 16'd0);
    send_voxel(20'hFFFFF, 20'hFFFFF);
    send_voxel(20'd0, 20'd64);
    drain();
  endtask

  task automatic test_config_sweep;
    src_idle  = 20;
    snk_stall = 20;
    repeat (4) begin
      set_config(16'($urandom_range(16, 800)), 16'($urandom_range(0, 200)),
                 16'($urandom), 16'($urandom));
      send_random(30);
      drain();
    end
    set_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_random(20);
    drain();
  endtask

  task automatic test_idle_phases;
    set_config(16'd160, 16'd48, 16'd512, 16'd1152);
    src_idle = 0;  snk_stall = 0;  send_random(95);
    src_idle = 48; snk_stall = 0;  send_random(95);
    src_idle = 0;  snk_stall = 48; send_random(95);
    src_idle = 14; snk_stall = 14; send_random(95);
    drain();
  endtask

  task automatic test_backpressure;
    src_idle  = 0;
    snk_stall = 0;
    set_config(16'd320, 16'd96, 16'd1024, 16'd900);
    // Hold the output long enough that the pipeline fills and stalls its input.
    fork
      begin
        @(negedge clk);
        hold_req = 300;
      end
    join_none
    send_random(100);
    drain();
    send_random(20);
    drain();
  endtask

  initial begin
    voxel_ch.valid     = 1'b0;
    voxel_ch.tissue_t1 = '0;
    voxel_ch.tissue_t2 = '0;
    tr_reg  = 16'd80;
    te_reg  = 16'd32;
    gd_reg  = 14'd0;
    rel_reg = 12'd1152;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_idle_phases();
    test_backpressure();

    $display("Streamed %0d voxels over directed corners, register sweeps, idle/stall mixes",
             voxels_sent);
    $display("and a long output hold-off; %0d intensity beats checked.", beats_checked);
    if (errors == 0) begin
      $display("gre_voxel_intensity_core: match");
    end else begin
      $display("gre_voxel_intensity_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/gvi_pkg.sv
rtl/gvi_voxel_if.sv
rtl/gvi_intensity_if.sv
rtl/gvi_cfg.sv
rtl/gvi_rate.sv
rtl/gvi_exp.sv
rtl/gvi_signal.sv
rtl/gre_voxel_intensity_core.sv
rtl/gvi_checker.sv
tb/tb_top.sv
